// ===== src/prsc_pkg.sv =====
// Shared types, constants and codes for the page run segment coalescer.
// Depends on nothing; every other file in src imports it.
package prsc_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int PAGE_SHIFT    = 12;
	localparam int TABLE_SLACK   = 5;

	localparam int AW          = $clog2(TABLE_ENTRIES);
	localparam int CW          = $clog2(TABLE_ENTRIES + 1);
	localparam int FULL_LIMIT  = TABLE_ENTRIES - TABLE_SLACK;
	localparam int MAX_COUNT   = FULL_LIMIT + 1;

	localparam int ADDR_W  = 48;
	localparam int SIZE_W  = 40;
	localparam int RUN_W   = 16;
	localparam int KIND_W  = 8;
	localparam int IDX_W   = 6;
	localparam int STAT_W  = 3;
	localparam int PC_W    = 24;
	localparam int NOTE_W  = 16;
	localparam int HB_W    = 8;
	localparam int PN_W    = ADDR_W - PAGE_SHIFT;
	localparam int PROD_W  = CW + HB_W;
	localparam int HDR_W   = ((PROD_W > NOTE_W) ? PROD_W : NOTE_W) + 2;

	localparam int CFG_AW  = 4;
	localparam int CFG_DW  = 32;

	localparam logic [PC_W-1:0]   PAGE_COUNT_RST = '0;
	localparam logic [NOTE_W-1:0] NOTE_BYTES_RST = NOTE_W'(356);
	localparam logic [HB_W-1:0]   FILE_HDR_RST   = HB_W'(64);
	localparam logic [HB_W-1:0]   ENTRY_HDR_RST  = HB_W'(56);

	typedef enum logic [STAT_W-1:0] {
		ST_MERGED = 3'd0,
		ST_NEW    = 3'd1,
		ST_RANGE  = 3'd2,
		ST_FULL   = 3'd3,
		ST_LAYOUT = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REQ_ADD = 1'b0,
		REQ_FIN = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		REG_PAGE_COUNT = 2'd0,
		REG_NOTE_BYTES = 2'd1,
		REG_FILE_HDR   = 2'd2,
		REG_ENTRY_HDR  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_MERGE,
		S_MRG_OUT,
		S_NEW_OUT,
		S_RNG_OUT,
		S_FULL_OUT,
		S_FIN_MUL,
		S_FIN_NOTE,
		S_FIN_RD,
		S_FIN_OUT
	} fsm_t;

	typedef enum logic [2:0] {
		SEL_MERGE,
		SEL_NEW,
		SEL_RANGE,
		SEL_FULL,
		SEL_NOTE,
		SEL_SEG
	} out_sel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] phys;
		logic [ADDR_W-1:0] virt;
		logic [SIZE_W-1:0] size;
		logic [KIND_W-1:0] kind;
	} seg_t;

	typedef struct packed {
		logic     ld_req;
		logic     ptr_rst;
		logic     rd_en;
		logic     ns_en;
		logic     mul_en;
		logic     mrg_wr;
		logic     app_wr;
		logic     run_init;
		logic     run_adv;
		logic     ld_out;
		out_sel_t out_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic scan_more;
		logic rd_pend;
		logic hit;
		logic tbl_full;
		logic note_last;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/prsc_ctrl.sv =====
// Sequencer for the coalescer: walks add and finalize requests through
// the datapath by command and status. Depends on prsc_pkg.
module prsc_ctrl import prsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       req_type,
	output logic       in_stall,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (req_t'(req_type) == REQ_FIN) ? S_FIN_MUL : S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.range_ok ? S_SEARCH : S_RNG_OUT;
			end
			S_SEARCH: begin
				if (stat.hit) begin
					state_d = S_MERGE;
				end else if (!stat.rd_pend && !stat.scan_more) begin
					state_d = stat.tbl_full ? S_FULL_OUT : S_NEW_OUT;
				end
			end
			S_MERGE: begin
				state_d = S_MRG_OUT;
			end
			S_MRG_OUT, S_NEW_OUT, S_RNG_OUT, S_FULL_OUT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FIN_MUL: begin
				state_d = S_FIN_NOTE;
			end
			S_FIN_NOTE: begin
				if (stat.out_free) begin
					state_d = stat.note_last ? S_IDLE : S_FIN_RD;
				end
			end
			S_FIN_RD: begin
				state_d = S_FIN_OUT;
			end
			S_FIN_OUT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.ld_req = in_valid;
			end
			S_CHECK: begin
				cmd.ptr_rst = 1'b1;
			end
			S_SEARCH: begin
				cmd.rd_en = stat.scan_more && !stat.hit;
			end
			S_MERGE: begin
				cmd.ns_en = 1'b1;
			end
			S_MRG_OUT: begin
				cmd.ld_out  = stat.out_free;
				cmd.mrg_wr  = stat.out_free;
				cmd.out_sel = SEL_MERGE;
			end
			S_NEW_OUT: begin
				cmd.ld_out  = stat.out_free;
				cmd.app_wr  = stat.out_free;
				cmd.out_sel = SEL_NEW;
			end
			S_RNG_OUT: begin
				cmd.ld_out  = stat.out_free;
				cmd.out_sel = SEL_RANGE;
			end
			S_FULL_OUT: begin
				cmd.ld_out  = stat.out_free;
				cmd.out_sel = SEL_FULL;
			end
			S_FIN_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.ptr_rst = 1'b1;
			end
			S_FIN_NOTE: begin
				cmd.ld_out   = stat.out_free;
				cmd.run_init = stat.out_free;
				cmd.out_sel  = SEL_NOTE;
			end
			S_FIN_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_FIN_OUT: begin
				cmd.ld_out  = stat.out_free;
				cmd.run_adv = stat.out_free;
				cmd.rd_en   = stat.out_free && !stat.emit_last;
				cmd.out_sel = SEL_SEG;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/prsc_dp.sv =====
// Datapath of the coalescer: request hold, segment table memory, match
// and merge arithmetic, layout offsets and the result register.
// Depends on prsc_pkg; driven by prsc_ctrl.
module prsc_dp import prsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ADDR_W-1:0]   phys_addr,
	input  logic [ADDR_W-1:0]   virt_addr,
	input  logic [RUN_W-1:0]    run_bytes,
	input  logic [KIND_W-1:0]   page_kind,
	input  logic [PC_W-1:0]     page_count,
	input  logic [NOTE_W-1:0]   note_bytes,
	input  logic [HB_W-1:0]     file_header_bytes,
	input  logic [HB_W-1:0]     entry_header_bytes,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [STAT_W-1:0]   status,
	output logic [IDX_W-1:0]    entry_index,
	output logic [ADDR_W-1:0]   seg_phys,
	output logic [ADDR_W-1:0]   seg_virt,
	output logic [SIZE_W-1:0]   seg_bytes,
	output logic [SIZE_W-1:0]   seg_offset,
	output logic [SIZE_W-1:0]   largest_compressed,
	output logic                last
);

	logic [ADDR_W-1:0] req_phys_q;
	logic [ADDR_W-1:0] req_virt_q;
	logic [RUN_W-1:0]  req_bytes_q;
	logic [KIND_W-1:0] req_kind_q;

	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     ptr_q;
	logic [SIZE_W-1:0] largest_q;
	logic [SIZE_W-1:0] ns_q;
	logic [PROD_W-1:0] prod_q;
	logic [HDR_W-1:0]  hdrs_q;
	logic [SIZE_W-1:0] run_q;

	seg_t              seg_mem_q [TABLE_ENTRIES];
	seg_t              rd_s1;
	logic [CW-1:0]     rd_idx_s1;
	logic              rd_vld_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] phys_q;
	logic [ADDR_W-1:0] virt_q;
	logic [SIZE_W-1:0] bytes_q;
	logic [SIZE_W-1:0] off_q;
	logic [SIZE_W-1:0] lz_q;
	logic              last_q;

	logic [ADDR_W:0]   phys_end;
	logic [ADDR_W:0]   virt_end;
	logic [SIZE_W:0]   size_sum;
	logic [SIZE_W-1:0] ns_sat;
	logic [SIZE_W-1:0] lz_next;
	logic [PN_W-1:0]   page_num;
	logic [HDR_W-1:0]  note_off;
	logic [HDR_W-1:0]  hdr_sum;
	logic [SIZE_W-1:0] seg_off;
	logic              out_free;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	seg_t              wr_data;

	status_t           o_status;
	logic [IDX_W-1:0]  o_idx;
	logic [ADDR_W-1:0] o_phys;
	logic [ADDR_W-1:0] o_virt;
	logic [SIZE_W-1:0] o_bytes;
	logic [SIZE_W-1:0] o_off;
	logic [SIZE_W-1:0] o_lz;
	logic              o_last;

	// hold the request
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_phys_q  <= phys_addr;
			req_virt_q  <= virt_addr;
			req_bytes_q <= run_bytes;
			req_kind_q  <= page_kind;
		end
	end

	// page range check
	assign page_num = req_phys_q[ADDR_W-1:PAGE_SHIFT];

	// match against the entry just read
	assign phys_end = {1'b0, rd_s1.phys} + (ADDR_W+1)'(rd_s1.size);
	assign virt_end = {1'b0, rd_s1.virt} + (ADDR_W+1)'(rd_s1.size);

	// merged size, saturating
	assign size_sum = {1'b0, rd_s1.size} + (SIZE_W+1)'(req_bytes_q);
	assign ns_sat   = size_sum[SIZE_W] ? '1 : size_sum[SIZE_W-1:0];
	assign lz_next  = ((rd_s1.kind != '0) && (ns_q > largest_q)) ? ns_q : largest_q;

	// layout offsets
	assign note_off = HDR_W'(file_header_bytes) + HDR_W'(prod_q);
	assign hdr_sum  = note_off + HDR_W'(note_bytes);
	assign seg_off  = (rd_s1.kind == '0) ? run_q : SIZE_W'(hdrs_q);

	assign out_free = !out_valid_q || !out_stall;

	assign stat.range_ok  = (page_num != '0) && ((page_num - PN_W'(1)) <= PN_W'(page_count));
	assign stat.scan_more = (ptr_q < cnt_q);
	assign stat.rd_pend   = rd_vld_s1;
	assign stat.hit       = rd_vld_s1 && (phys_end == {1'b0, req_phys_q})
	                        && (virt_end == {1'b0, req_virt_q}) && (rd_s1.kind == req_kind_q);
	assign stat.tbl_full  = (cnt_q > CW'(FULL_LIMIT));
	assign stat.note_last = (cnt_q <= CW'(1));
	assign stat.emit_last = ((rd_idx_s1 + CW'(1)) >= cnt_q);
	assign stat.out_free  = out_free;

	// segment table: one write port, one registered read port
	assign wr_en   = cmd.mrg_wr || cmd.app_wr;
	assign wr_addr = cmd.mrg_wr ? rd_idx_s1[AW-1:0] : cnt_q[AW-1:0];
	always_comb begin
		if (cmd.mrg_wr) begin
			wr_data = '{phys: rd_s1.phys, virt: rd_s1.virt, size: ns_q, kind: rd_s1.kind};
		end else begin
			wr_data = '{phys: req_phys_q, virt: req_virt_q,
			            size: SIZE_W'(req_bytes_q), kind: req_kind_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_s1     <= seg_mem_q[ptr_q[AW-1:0]];
			rd_idx_s1 <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CW'(1);
			ptr_q     <= '0;
			largest_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.ptr_rst) begin
				ptr_q <= CW'(1);
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.app_wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.mrg_wr) begin
				largest_q <= lz_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ns_en) begin
			ns_q <= ns_sat;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(cnt_q) * PROD_W'(entry_header_bytes);
		end
		if (cmd.run_init) begin
			hdrs_q <= hdr_sum;
			run_q  <= SIZE_W'(hdr_sum);
		end else if (cmd.run_adv && (rd_s1.kind == '0)) begin
			run_q <= run_q + rd_s1.size;
		end
	end

	// result select
	always_comb begin
		o_status = ST_LAYOUT;
		o_idx    = '0;
		o_phys   = '0;
		o_virt   = '0;
		o_bytes  = '0;
		o_off    = '0;
		o_lz     = largest_q;
		o_last   = 1'b1;
		unique case (cmd.out_sel)
			SEL_MERGE: begin
				o_status = ST_MERGED;
				o_idx    = IDX_W'(rd_idx_s1);
				o_phys   = rd_s1.phys;
				o_virt   = rd_s1.virt;
				o_bytes  = ns_q;
				o_lz     = lz_next;
			end
			SEL_NEW: begin
				o_status = ST_NEW;
				o_idx    = IDX_W'(cnt_q);
				o_phys   = req_phys_q;
				o_virt   = req_virt_q;
				o_bytes  = SIZE_W'(req_bytes_q);
			end
			SEL_RANGE: begin
				o_status = ST_RANGE;
			end
			SEL_FULL: begin
				o_status = ST_FULL;
			end
			SEL_NOTE: begin
				o_bytes = SIZE_W'(note_bytes);
				o_off   = SIZE_W'(note_off);
				o_last  = stat.note_last;
			end
			SEL_SEG: begin
				o_idx   = IDX_W'(rd_idx_s1);
				o_phys  = rd_s1.phys;
				o_virt  = rd_s1.virt;
				o_bytes = rd_s1.size;
				o_off   = seg_off;
				o_last  = stat.emit_last;
			end
			default: begin
				o_status = ST_LAYOUT;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			status_q <= o_status;
			idx_q    <= o_idx;
			phys_q   <= o_phys;
			virt_q   <= o_virt;
			bytes_q  <= o_bytes;
			off_q    <= o_off;
			lz_q     <= o_lz;
			last_q   <= o_last;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign entry_index        = idx_q;
	assign seg_phys           = phys_q;
	assign seg_virt           = virt_q;
	assign seg_bytes          = bytes_q;
	assign seg_offset         = off_q;
	assign largest_compressed = lz_q;
	assign last               = last_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && cmd.rd_en))
		else $error("segment table written and read in one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(MAX_COUNT)))
		else $error("entry count out of range");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> out_free)
		else $error("result register overwritten while held");

	a_largest_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (largest_q >= $past(largest_q)))
		else $error("largest compressed size decreased");

endmodule

// ===== src/page_run_segment_coalescer_top.sv =====
// Top level of the page run segment coalescer: configuration registers
// behind an APB-style port, sequencer and datapath. Depends on prsc_pkg,
// prsc_ctrl and prsc_dp.
//
// Add: the page range is checked first and a rejected page goes straight to the output
//   register; an accepted page is scanned against the table at one entry a cycle through
//   the single registered memory read port, a match acted on as soon as its entry is read.
// Items are taken one at a time. A finalize works out the header offsets, emits the note
//   result, reads the first segment, then emits one segment per cycle while the output
//   side does not stall; a new item is taken once the last result is loaded.
// Reset: arst_n clears the sequencer, entry count (to one, note reserved), the
//   largest compressed size and the registers to their defaults. Table contents
//   stay undefined until written; no clearing pass is run.
module page_run_segment_coalescer_top import prsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [ADDR_W-1:0]   phys_addr,
	input  logic [ADDR_W-1:0]   virt_addr,
	input  logic [RUN_W-1:0]    run_bytes,
	input  logic [KIND_W-1:0]   page_kind,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [IDX_W-1:0]    entry_index,
	output logic [ADDR_W-1:0]   seg_phys,
	output logic [ADDR_W-1:0]   seg_virt,
	output logic [SIZE_W-1:0]   seg_bytes,
	output logic [SIZE_W-1:0]   seg_offset,
	output logic [SIZE_W-1:0]   largest_compressed,
	output logic                last,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	output logic                pready
);

	logic [PC_W-1:0]   page_count_q;
	logic [NOTE_W-1:0] note_bytes_q;
	logic [HB_W-1:0]   file_hdr_q;
	logic [HB_W-1:0]   entry_hdr_q;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	ctrl_cmd_t         cmd;
	dp_stat_t          stat;

	// Registers sit one word apart; the write lands on the access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PAGE_COUNT_RST;
			note_bytes_q <= NOTE_BYTES_RST;
			file_hdr_q   <= FILE_HDR_RST;
			entry_hdr_q  <= ENTRY_HDR_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PAGE_COUNT: page_count_q <= pwdata[PC_W-1:0];
				REG_NOTE_BYTES: note_bytes_q <= pwdata[NOTE_W-1:0];
				REG_FILE_HDR:   file_hdr_q   <= pwdata[HB_W-1:0];
				REG_ENTRY_HDR:  entry_hdr_q  <= pwdata[HB_W-1:0];
				default: begin
					page_count_q <= page_count_q;
				end
			endcase
		end
	end

	// Read back: zero-extend each register to the bus width.
	always_comb begin
		unique case (cfg_idx)
			REG_PAGE_COUNT: prdata = CFG_DW'(page_count_q);
			REG_NOTE_BYTES: prdata = CFG_DW'(note_bytes_q);
			REG_FILE_HDR:   prdata = CFG_DW'(file_hdr_q);
			REG_ENTRY_HDR:  prdata = CFG_DW'(entry_hdr_q);
			default:        prdata = '0;
		endcase
	end

	// Sequencer: takes an item only when idle, then steps the datapath.
	prsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: segment table, match/merge arithmetic and the result register
	// that parts the output side from the sequencer.
	prsc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.phys_addr          (phys_addr),
		.virt_addr          (virt_addr),
		.run_bytes          (run_bytes),
		.page_kind          (page_kind),
		.page_count         (page_count_q),
		.note_bytes         (note_bytes_q),
		.file_header_bytes  (file_hdr_q),
		.entry_header_bytes (entry_hdr_q),
		.cmd                (cmd),
		.stat               (stat),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.status             (status),
		.entry_index        (entry_index),
		.seg_phys           (seg_phys),
		.seg_virt           (seg_virt),
		.seg_bytes          (seg_bytes),
		.seg_offset         (seg_offset),
		.largest_compressed (largest_compressed),
		.last               (last)
	);

endmodule

// ===== tb/page_run_segment_coalescer_top_test.sv =====
// Self-checking testbench for page_run_segment_coalescer_top: builds, extends and rejects
// page runs, fills the segment table and checks every layout against a built-in predictor.
// Depends on prsc_pkg and the block's RTL only.
module page_run_segment_coalescer_top_test;
	import prsc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	// one result as the block should present it
	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  index;
		logic [ADDR_W-1:0] phys;
		logic [ADDR_W-1:0] virt;
		logic [SIZE_W-1:0] bytes;
		logic [SIZE_W-1:0] offset;
		logic [SIZE_W-1:0] largest;
		logic              last;
	} seg_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                req_type = 1'b0;
	logic [ADDR_W-1:0]   phys_addr = '0;
	logic [ADDR_W-1:0]   virt_addr = '0;
	logic [RUN_W-1:0]    run_bytes = '0;
	logic [KIND_W-1:0]   page_kind = '0;

	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [IDX_W-1:0]    entry_index;
	logic [ADDR_W-1:0]   seg_phys;
	logic [ADDR_W-1:0]   seg_virt;
	logic [SIZE_W-1:0]   seg_bytes;
	logic [SIZE_W-1:0]   seg_offset;
	logic [SIZE_W-1:0]   largest_compressed;
	logic                last;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CFG_AW-1:0]   paddr = '0;
	logic [CFG_DW-1:0]   pwdata = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	// predictor copy of the segment table; entries at or above seg_total are never read
	logic [ADDR_W-1:0]   tbl_phys [TABLE_ENTRIES];
	logic [ADDR_W-1:0]   tbl_virt [TABLE_ENTRIES];
	logic [SIZE_W-1:0]   tbl_size [TABLE_ENTRIES];
	logic [KIND_W-1:0]   tbl_kind [TABLE_ENTRIES];
	int unsigned         seg_total = 1;
	logic [SIZE_W-1:0]   largest_cmp = '0;

	logic [PC_W-1:0]     cfg_page_count = PAGE_COUNT_RST;
	logic [NOTE_W-1:0]   cfg_note = NOTE_BYTES_RST;
	logic [HB_W-1:0]     cfg_file_hdr = FILE_HDR_RST;
	logic [HB_W-1:0]     cfg_entry_hdr = ENTRY_HDR_RST;

	seg_report_t         pending_reports[$];
	int                  mismatch_count = 0;
	int unsigned         cycle_count = 0;
	bit                  quiet = 1'b0;

	page_run_segment_coalescer_top u_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void post_report(status_t st, int unsigned idx, logic [ADDR_W-1:0] ph,
			logic [ADDR_W-1:0] vi, logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] off, logic lst);
		seg_report_t r;
		r.status = st;
		r.index = IDX_W'(idx);
		r.phys = ph;
		r.virt = vi;
		r.bytes = sz;
		r.offset = off;
		r.largest = largest_cmp;
		r.last = lst;
		pending_reports.push_back(r);
	endfunction

	// Work out the results of one accepted item and advance the predicted table.
	function automatic void coalesce_predict(req_t rq, logic [ADDR_W-1:0] ph,
			logic [ADDR_W-1:0] vi, logic [RUN_W-1:0] rb, logic [KIND_W-1:0] pk);
		logic [63:0] hdrs;
		logic [63:0] run_off;
		logic [63:0] grown;
		logic [PN_W-1:0] pn;
		int unsigned i;
		if (rq == REQ_FIN) begin
			hdrs = 64'(cfg_file_hdr) + 64'(seg_total) * 64'(cfg_entry_hdr) + 64'(cfg_note);
			run_off = hdrs;
			post_report(ST_LAYOUT, 0, '0, '0, SIZE_W'(cfg_note), SIZE_W'(hdrs - 64'(cfg_note)),
				seg_total == 1);
			for (i = 1; i < seg_total; i++) begin
				// uncompressed segments are laid out back to back, compressed ones point at
				// the end of the headers
				if (tbl_kind[i] == '0) begin
					post_report(ST_LAYOUT, i, tbl_phys[i], tbl_virt[i], tbl_size[i],
						SIZE_W'(run_off), i + 1 == seg_total);
					run_off = (run_off + 64'(tbl_size[i])) & 64'(SIZE_MAX);
				end else begin
					post_report(ST_LAYOUT, i, tbl_phys[i], tbl_virt[i], tbl_size[i],
						SIZE_W'(hdrs), i + 1 == seg_total);
				end
			end
			return;
		end
		pn = PN_W'(ph >> PAGE_SHIFT);
		if (pn == '0 || 64'(pn) - 64'd1 > 64'(cfg_page_count)) begin
			post_report(ST_RANGE, 0, '0, '0, '0, '0, 1'b1);
			return;
		end
		for (i = 1; i < seg_total; i++) begin
			if (64'(tbl_phys[i]) + 64'(tbl_size[i]) == 64'(ph) &&
					64'(tbl_virt[i]) + 64'(tbl_size[i]) == 64'(vi) && tbl_kind[i] == pk) begin
				grown = 64'(tbl_size[i]) + 64'(rb);
				if (grown > 64'(SIZE_MAX))
					grown = 64'(SIZE_MAX);
				tbl_size[i] = SIZE_W'(grown);
				if (pk != '0 && tbl_size[i] > largest_cmp)
					largest_cmp = tbl_size[i];
				post_report(ST_MERGED, i, tbl_phys[i], tbl_virt[i], tbl_size[i], '0, 1'b1);
				return;
			end
		end
		if (seg_total > FULL_LIMIT) begin
			post_report(ST_FULL, 0, '0, '0, '0, '0, 1'b1);
			return;
		end
		tbl_phys[seg_total] = ph;
		tbl_virt[seg_total] = vi;
		tbl_size[seg_total] = SIZE_W'(rb);
		tbl_kind[seg_total] = pk;
		seg_total++;
		post_report(ST_NEW, seg_total - 1, ph, vi, SIZE_W'(rb), '0, 1'b1);
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t  %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// Present one item, hold it until taken, then predict its results.
	// Valid stays high on return so that a following item can go straight out.
	task automatic send_request(req_t rq, logic [ADDR_W-1:0] ph, logic [ADDR_W-1:0] vi,
			logic [RUN_W-1:0] rb, logic [KIND_W-1:0] pk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= rq;
		phys_addr <= ph;
		virt_addr <= vi;
		run_bytes <= rb;
		page_kind <= pk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		coalesce_predict(rq, ph, vi, rb, pk);
	endtask

	// Drop valid and hold off until every predicted result has been taken.
	task automatic await_results(int unsigned settle);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [CFG_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PAGE_COUNT: cfg_page_count = PC_W'(value);
			REG_NOTE_BYTES: cfg_note = NOTE_W'(value);
			REG_FILE_HDR:   cfg_file_hdr = HB_W'(value);
			REG_ENTRY_HDR:  cfg_entry_hdr = HB_W'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Registers change only with the block drained.
	task automatic configure(logic [PC_W-1:0] pc, logic [NOTE_W-1:0] nb, logic [HB_W-1:0] fh,
			logic [HB_W-1:0] eh);
		await_results(4);
		write_register(REG_PAGE_COUNT, CFG_DW'(pc));
		write_register(REG_NOTE_BYTES, CFG_DW'(nb));
		write_register(REG_FILE_HDR, CFG_DW'(fh));
		write_register(REG_ENTRY_HDR, CFG_DW'(eh));
	endtask

	// Out of reset: empty layout with default sizes, then the one-page window of a zero
	// page count.
	task automatic test_empty_layout();
		send_request(REQ_FIN, '0, '0, '0, '0);
		send_request(REQ_ADD, 48'h0000_0000_0fff, 48'h0, 16'h0010, 8'h00);
		send_request(REQ_ADD, 48'h0000_0000_1000, 48'h0000_0000_1000, 16'h0010, 8'h00);
		send_request(REQ_ADD, 48'h0000_0000_2000, 48'h0000_0000_2000, 16'h0010, 8'h00);
		send_request(REQ_FIN, '0, '0, '0, '0);
	endtask

	// Widest window: last legal page, first page past it, top address, and a run that
	// continues the page-one segment stored by the empty-layout test.
	task automatic test_page_window();
		configure(24'hFF_FFFF, NOTE_BYTES_RST, FILE_HDR_RST, ENTRY_HDR_RST);
		send_request(REQ_ADD, 48'h0010_0000_0000, 48'h0000_0000_4000, 16'h0800, 8'h00);
		send_request(REQ_ADD, 48'h0010_0000_1000, 48'h0000_0000_5000, 16'h0800, 8'h00);
		send_request(REQ_ADD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
		send_request(REQ_ADD, 48'h0000_0000_1010, 48'h0000_0000_1010, 16'h0020, 8'h00);
	endtask

	// Merge rules: plain and compressed merges, a compressed merge too small to set a new
	// largest size, and runs broken by kind or by virtual address.
	task automatic test_merge_rules();
		send_request(REQ_ADD, 48'h0000_1234_5000, 48'hFFFF_FFFF_0000, 16'hFFFF, 8'h00);
		send_request(REQ_ADD, 48'h0000_1235_4FFF, 48'hFFFF_FFFF_FFFF, 16'h0000, 8'h00);
		send_request(REQ_ADD, 48'h0000_8000_0000, 48'h0000_8000_0000, 16'h1000, 8'hFF);
		send_request(REQ_ADD, 48'h0000_8000_1000, 48'h0000_8000_1000, 16'h3000, 8'hFF);
		send_request(REQ_ADD, 48'h0000_9000_0000, 48'h0000_0000_0000, 16'h0100, 8'h01);
		send_request(REQ_ADD, 48'h0000_9000_0100, 48'h0000_0000_0100, 16'h0100, 8'h01);
		send_request(REQ_ADD, 48'h0000_9000_0200, 48'h0000_0000_0200, 16'h0080, 8'h02);
		send_request(REQ_ADD, 48'h0000_8000_4000, 48'h0000_8000_4001, 16'h0010, 8'hFF);
		send_request(REQ_FIN, '0, '0, '0, '0);
	endtask

	// Mostly continuations of stored runs, so the table fills and stays busy; the rest are
	// fresh segments, broken continuations, pages outside the window and layouts.
	task automatic test_random_traffic(int unsigned items, logic [PC_W-1:0] pc,
			logic [NOTE_W-1:0] nb, logic [HB_W-1:0] fh, logic [HB_W-1:0] eh, bit calm_tail);
		int unsigned n;
		int unsigned pick;
		int unsigned slot;
		int unsigned pn_new;
		logic [ADDR_W-1:0] ph;
		logic [ADDR_W-1:0] vi;
		logic [KIND_W-1:0] pk;
		configure(pc, nb, fh, eh);
		ph = '0;
		for (n = 0; n < items; n++) begin
			if (calm_tail && n >= items * 2 / 3)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			vi = 48'({$urandom(), $urandom()});
			pk = ($urandom_range(0, 1) == 0) ? '0 : KIND_W'($urandom());
			if (pick < 55 && seg_total > 1) begin
				slot = $urandom_range(1, seg_total - 1);
				ph = tbl_phys[slot] + ADDR_W'(tbl_size[slot]);
				vi = tbl_virt[slot] + ADDR_W'(tbl_size[slot]);
				pk = tbl_kind[slot];
				// knock one field off now and then so the run cannot be extended
				case ($urandom_range(0, 9))
					0: vi = vi ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
					1: pk = pk ^ (KIND_W'(1) << $urandom_range(0, KIND_W - 1));
					2: ph = ph + ADDR_W'($urandom_range(1, 4095));
					default: ;
				endcase
				send_request(REQ_ADD, ph, vi, RUN_W'($urandom()), pk);
			end else if (pick < 82) begin
				pn_new = $urandom_range(1, 32'(cfg_page_count) + 1);
				ph = (ADDR_W'(pn_new) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, 4095));
				send_request(REQ_ADD, ph, vi, RUN_W'($urandom()), pk);
			end else if (pick < 93) begin
				case ($urandom_range(0, 2))
					0: ph = ADDR_W'($urandom_range(0, 4095));
					1: ph = (ADDR_W'(cfg_page_count) + ADDR_W'(2)) << PAGE_SHIFT;
					default: ph = 48'({$urandom(), $urandom()}) | {1'b1, {(ADDR_W - 1){1'b0}}};
				endcase
				send_request(REQ_ADD, ph, vi, RUN_W'($urandom()), pk);
			end else begin
				send_request(REQ_FIN, ph, vi, RUN_W'($urandom()), pk);
			end
		end
		// close every setting with a full layout
		send_request(REQ_FIN, '0, '0, '0, '0);
	endtask

	// Result stall: random bursts, with calm stretches in between.
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 63) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// Compare each taken result with the oldest prediction.
	always @(posedge clk) begin : result_check
		seg_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t  unexpected result: status %0d, index %0d", $time, status,
					entry_index);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("entry_index", 64'(want.index), 64'(entry_index));
				check_field("seg_phys", 64'(want.phys), 64'(seg_phys));
				check_field("seg_virt", 64'(want.virt), 64'(seg_virt));
				check_field("seg_bytes", 64'(want.bytes), 64'(seg_bytes));
				check_field("seg_offset", 64'(want.offset), 64'(seg_offset));
				check_field("largest_compressed", 64'(want.largest), 64'(largest_compressed));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t  timeout after %0d cycles", $time, cycle_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_layout();
		test_page_window();
		test_merge_rules();
		test_random_traffic(52, 24'hFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
		test_random_traffic(52, 24'($urandom_range(24'h00_1000, 24'hFF_FFFF)), 16'h0000,
			8'h00, 8'h00, 1'b0);
		test_random_traffic(52, 24'($urandom_range(24'h00_1000, 24'hFF_FFFF)),
			16'($urandom()), 8'($urandom()), 8'($urandom()), 1'b0);
		test_random_traffic(52, 24'hFF_FFFF, NOTE_BYTES_RST, FILE_HDR_RST, ENTRY_HDR_RST, 1'b1);
		await_results(80);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
src/prsc_pkg.sv
src/prsc_ctrl.sv
src/prsc_dp.sv
src/page_run_segment_coalescer_top.sv
tb/page_run_segment_coalescer_top_test.sv
